>>> rtl/cnr_pkg.sv
// package for the channel nibble repacker: mode codes, tags and word sizes
package cnr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned AccW    = 3;
  localparam int unsigned CntW    = 2;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned ResIdxW = $clog2(MaxRes);

  // channel tag in bit 7 of a result word
  localparam logic [ByteW-1:0] ChanTag = 8'h80;

  typedef enum logic [ModeW-1:0] {
    ModePass = 2'd0,
    ModeTwo  = 2'd1,
    ModeOne  = 2'd2
  } mode_e;

  typedef logic [ByteW-1:0] res_word_t;

endpackage

>>> rtl/channel_nibble_repacker_core.sv
// channel nibble repacker: raw source bytes in, channel-tagged nibbles out
// a byte accepted at one edge shows its first result word in the next cycle
// words per byte: pass-through one, two-channel one or two, one-channel four;
//   the single result register hands out one word a cycle unless stalled
// a new byte is taken in the same cycle the last word of the previous one leaves
// reset (rst_ni low, asynchronous) clears the mode to pass-through, both
//   channel accumulators and the output valid
module channel_nibble_repacker_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: channel_mode
  input  logic                       cfg_we_i,
  input  logic [cnr_pkg::ModeW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [cnr_pkg::ByteW-1:0]  s_axis_tdata,   // [7:0] in_byte
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [cnr_pkg::ByteW-1:0]  m_axis_tdata,   // [7:0] out_value
  output logic                       m_axis_tlast    // last word caused by a byte
);
  import cnr_pkg::*;

  // configuration and channel state
  logic [ModeW-1:0] mode_q;
  logic [AccW-1:0]  bits0_q, bits0_d;
  logic [CntW-1:0]  cnt0_q, cnt0_d;
  logic [AccW-1:0]  bits1_q, bits1_d;
  logic [CntW-1:0]  cnt1_q, cnt1_d;

  // result register: up to four words per byte, read out by index
  res_word_t [MaxRes-1:0] res_q, res_d;
  logic [ResIdxW-1:0]     last_idx_q, last_idx_d;
  logic [ResIdxW-1:0]     idx_q;
  logic                   valid_q;

  logic in_fire, out_fire, at_final;

  // two-channel datapath
  logic             sel_ch;
  logic [AccW-1:0]  two_bits;
  logic [CntW-1:0]  two_cnt;
  logic [10:0]      two_acc;
  logic             two_single;
  logic [CntW-1:0]  two_cnt_new;
  logic [AccW-1:0]  two_mask;
  logic [AccW-1:0]  two_bits_new;
  res_word_t        two_tag;

  // one-channel datapath: carried bit below the byte
  logic [8:0]       one_s;

  assign out_fire      = valid_q && m_axis_tready;
  assign at_final      = (idx_q == last_idx_q);
  // the result register frees up when its final word is taken
  assign s_axis_tready = !valid_q || (m_axis_tready && at_final);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q[idx_q];
  assign m_axis_tlast  = at_final;

  // bit 7 picks the channel, the 7 payload bits go in above the pending ones
  assign sel_ch     = s_axis_tdata[ByteW-1];
  assign two_bits   = sel_ch ? bits1_q : bits0_q;
  assign two_cnt    = sel_ch ? cnt1_q : cnt0_q;
  assign two_tag    = sel_ch ? ChanTag : '0;
  assign two_acc    = {8'b0, two_bits}
                    | ({4'b0, s_axis_tdata[ByteW-2:0]} << two_cnt);
  // an empty accumulator yields one nibble, any pending bit makes it two
  assign two_single = (two_cnt == '0);
  // seven new bits less four or eight taken: count drops by one, mod four
  assign two_cnt_new = two_cnt - CntW'(1);

  always_comb begin
    case (two_cnt_new)
      2'd0:    two_mask = 3'b000;
      2'd1:    two_mask = 3'b001;
      2'd2:    two_mask = 3'b011;
      default: two_mask = 3'b111;
    endcase
  end

  assign two_bits_new = (two_single ? two_acc[6:4] : two_acc[10:8]) & two_mask;

  // one-channel mode ors the pending bits under the shifted byte
  assign one_s = {s_axis_tdata, 1'b0} | {6'b0, bits0_q};

  // next result words and channel state for the incoming byte
  always_comb begin
    res_d      = res_q;
    last_idx_d = last_idx_q;
    bits0_d    = bits0_q;
    cnt0_d     = cnt0_q;
    bits1_d    = bits1_q;
    cnt1_d     = cnt1_q;
    case (mode_q)
      ModeTwo: begin
        res_d[0]   = two_tag | {4'b0, two_acc[3:0]};
        res_d[1]   = two_tag | {4'b0, two_acc[7:4]};
        last_idx_d = two_single ? ResIdxW'(0) : ResIdxW'(1);
        if (sel_ch) begin
          bits1_d = two_bits_new;
          cnt1_d  = two_cnt_new;
        end else begin
          bits0_d = two_bits_new;
          cnt0_d  = two_cnt_new;
        end
      end
      ModeOne: begin
        res_d[0]   = ChanTag | {4'b0, one_s[4:1]};
        res_d[1]   = {4'b0, ~one_s[4:1] ^ one_s[3:0]};
        res_d[2]   = ChanTag | {4'b0, one_s[8:5]};
        res_d[3]   = {4'b0, ~one_s[8:5] ^ one_s[7:4]};
        last_idx_d = ResIdxW'(MaxRes - 1);
        // only the carried top bit stays
        bits0_d    = {2'b0, one_s[8]};
      end
      default: begin
        // pass-through, also the unused mode code
        res_d[0]   = s_axis_tdata;
        last_idx_d = '0;
      end
    endcase
  end

  // control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModePass;
      bits0_q    <= '0;
      cnt0_q     <= '0;
      bits1_q    <= '0;
      cnt1_q     <= '0;
      valid_q    <= 1'b0;
      idx_q      <= '0;
      last_idx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        bits0_q    <= bits0_d;
        cnt0_q     <= cnt0_d;
        bits1_q    <= bits1_d;
        cnt1_q     <= cnt1_d;
        valid_q    <= 1'b1;
        idx_q      <= '0;
        last_idx_q <= last_idx_d;
      end else if (out_fire) begin
        if (at_final) begin
          valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + ResIdxW'(1);
        end
      end
    end
  end

  // result words, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

endmodule

>>> rtl/cnr_checker.sv
// port-level checker for the channel nibble repacker, bound to channel_nibble_repacker_core
module cnr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [cnr_pkg::ByteW-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // no byte taken while results wait on a stalled output
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // an accepted byte always produces a word next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte produced no word");

  // a word that is not the last of its byte is followed by another
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("result words of a byte cut short");

endmodule

bind channel_nibble_repacker_core cnr_checker u_cnr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> dv/tb_top.sv
// testbench for channel_nibble_repacker_core: directed and random bytes in every mode, scored
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cnr_pkg::*;

  // mode register value the block treats as pass-through
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  // one expected output word
  typedef struct packed {
    res_word_t value;
    logic      last;
  } nib_word_t;

  // tracks the repacker state and holds the words still to come out
  class nibble_scoreboard;
    logic [ModeW-1:0] mode;
    logic [AccW-1:0]  ch0_bits;
    logic [CntW-1:0]  ch0_cnt;
    logic [AccW-1:0]  ch1_bits;
    logic [CntW-1:0]  ch1_cnt;
    nib_word_t        word_q[$];
    int unsigned      bytes_seen;
    int unsigned      words_checked;
    int unsigned      errors;

    function new();
      mode          = ModePass;
      ch0_bits      = '0;
      ch0_cnt       = '0;
      ch1_bits      = '0;
      ch1_cnt       = '0;
      bytes_seen    = 0;
      words_checked = 0;
      errors        = 0;
    endfunction

    function void set_mode(logic [ModeW-1:0] m);
      mode = m;
    endfunction

    function int unsigned pending();
      return word_q.size();
    endfunction

    // queue one expected word at the tail
    function void put_word(res_word_t value, logic last);
      nib_word_t w;
      w.value = value;
      w.last  = last;
      word_q.insert(word_q.size(), w);
    endfunction

    // predict the words caused by one accepted byte
    function void note_byte(res_word_t b);
      logic [10:0]     acc;
      logic [8:0]      s;
      logic [AccW-1:0] bits;
      logic [CntW-1:0] cnt;
      res_word_t       tag;
      int              n;
      int              k;
      bytes_seen++;
      if (mode == ModeTwo) begin
        // bit 7 picks the channel, 7 payload bits go in lsb first
        if (b[7]) begin
          bits = ch1_bits;
          cnt  = ch1_cnt;
          tag  = ChanTag;
        end else begin
          bits = ch0_bits;
          cnt  = ch0_cnt;
          tag  = '0;
        end
        acc = {8'b0, bits} | ({4'b0, b[6:0]} << cnt);
        n   = int'(cnt) + 7;
        k   = (n >= 8) ? 2 : 1;
        for (int i = 0; i < k; i++) begin
          put_word(tag | {4'b0, acc[3:0]}, (i == k - 1));
          acc = acc >> 4;
        end
        n    = n - 4 * k;
        bits = AccW'(acc & ((11'd1 << n) - 11'd1));
        cnt  = CntW'(n);
        if (b[7]) begin
          ch1_bits = bits;
          ch1_cnt  = cnt;
        end else begin
          ch0_bits = bits;
          ch0_cnt  = cnt;
        end
      end else if (mode == ModeOne) begin
        // whole accumulator is ored in, bit 0 carries the previous msb
        s = {6'b0, ch0_bits} | {b, 1'b0};
        put_word(ChanTag | {4'b0, s[4:1]}, 1'b0);
        put_word({4'b0, ~(s[4:1] ^ s[3:0])}, 1'b0);
        put_word(ChanTag | {4'b0, s[8:5]}, 1'b0);
        put_word({4'b0, ~(s[8:5] ^ s[7:4])}, 1'b1);
        ch0_bits = {2'b0, s[8]};
      end else begin
        put_word(b, 1'b1);
      end
    endfunction

    function void check_word(res_word_t value, logic last);
      nib_word_t exp_w;
      if (word_q.size() == 0) begin
        $display("%0t: unexpected word value=%02h last=%0b", $realtime, value, last);
        errors++;
        return;
      end
      exp_w = word_q.pop_front();
      words_checked++;
      if (value !== exp_w.value) begin
        $display("%0t: value mismatch expected=%02h actual=%02h",
                 $realtime, exp_w.value, value);
        errors++;
      end
      if (last !== exp_w.last) begin
        $display("%0t: last mismatch expected=%0b actual=%0b",
                 $realtime, exp_w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [ModeW-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata;   // [7:0] in_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [ByteW-1:0]     m_axis_tdata;   // [7:0] out_value
  logic                 m_axis_tlast;   // last word caused by a byte

  nibble_scoreboard sb = new();

  // sender gaps and receiver stalls, both switched off near the end
  bit gaps_on;
  bit stalls_on;

  channel_nibble_repacker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d words still expected", sb.pending());
    $display("[channel_nibble_repacker_core] ERROR");
    $finish;
  end

  // monitor: sample every handshake at the edge, before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        sb.set_mode(cfg_wdata_i);
      end
      // output first: a word always belongs to a byte taken at an earlier edge
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tdata, m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata);
      end
    end
  end

  // receiver: ready held high, dropped for random bursts while stalls are on
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // offer one byte, maybe after a random gap, and wait for the block to take it
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering and let every expected word drain out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    // step past the current edge first so the last accepted byte is already noted
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mode writes only happen with the block idle
  task automatic write_mode(input logic [ModeW-1:0] m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_list(input logic [ByteW-1:0] list[]);
    foreach (list[i]) send_byte(list[i]);
    drain();
  endtask

  initial begin
    logic [ModeW-1:0] phase_mode[6];
    logic [ByteW-1:0] b;
    bit               failed;

    // all inputs known from time zero
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pass-through extremes, then the unused mode code
    write_mode(ModePass);
    send_list('{8'h00, 8'hff, 8'h80, 8'h7f, 8'ha5});
    write_mode(ModeUnused);
    send_list('{8'h5a, 8'hc3});

    // two-channel: both channels, one and two nibbles per byte,
    // channel 0 left with a pending bit
    write_mode(ModeTwo);
    send_list('{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'haa});

    // one-channel right after, pending bits folded into the first word
    write_mode(ModeOne);
    send_list('{8'hff, 8'h00, 8'h80, 8'h01, 8'ha5});

    // back to two-channel with the carried bit still in channel 0
    write_mode(ModeTwo);
    send_list('{8'h2a, 8'hd5, 8'h40});

    // random phases over all mode codes, the last with no idling at all
    phase_mode = '{ModeTwo, ModeOne, ModePass, ModeUnused, ModeTwo, ModeOne};
    foreach (phase_mode[p]) begin
      if (p == 5) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      write_mode(phase_mode[p]);
      repeat (13) begin
        if ($urandom_range(0, 9) == 0) begin
          b = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end else begin
          b = ByteW'($urandom);
        end
        send_byte(b);
      end
      drain();
    end

    // quiet time at the end so a stray extra word would still be caught
    repeat (8) @(posedge clk_i);

    failed = (sb.errors != 0) || (sb.pending() != 0);
    if (sb.pending() != 0) begin
      $display("%0d expected words never arrived", sb.pending());
    end
    $display("ran %0d bytes through pass, unused, two- and one-channel modes",
             sb.bytes_seen);
    $display("checked %0d output words, %0d mismatches", sb.words_checked, sb.errors);
    if (!failed) begin
      $display("[channel_nibble_repacker_core] OK");
    end else begin
      $display("[channel_nibble_repacker_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cnr_pkg.sv
rtl/channel_nibble_repacker_core.sv
rtl/cnr_checker.sv
dv/tb_top.sv
